[hdl/sckm_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sckm_pkg
// Types, constants and key lookup tables for the scan code to key matrix
// driver.
// ---------------------------------------------------------------------------
package sckm_pkg;

  localparam int ActionWidth = 2;
  localparam int CodeWidth   = 8;
  localparam int FlagWidth   = 4;
  localparam int WordWidth   = 8;
  localparam int InDataWidth  = 16;
  localparam int OutDataWidth = 32;
  localparam int ApbAddrWidth = 3;
  localparam int ApbDataWidth = 32;

  localparam logic [WordWidth-1:0] HoldTicksReset = 8'd5;
  localparam logic [WordWidth-1:0] WordIdle  = 8'hFF;
  localparam logic [WordWidth-1:0] NoChar    = 8'hFF;

  // fixed words for break and caps lock
  localparam logic [WordWidth-1:0] BreakHigh = 8'hFB;
  localparam logic [WordWidth-1:0] BreakLow  = 8'h7F;
  localparam logic [WordWidth-1:0] BreakChar = 8'h5E;
  localparam logic [WordWidth-1:0] CapsHigh  = 8'h7E;
  localparam logic [WordWidth-1:0] CapsLow   = 8'h7E;
  localparam logic [WordWidth-1:0] CapsChar  = 8'h40;

  // modifier masks
  localparam logic [WordWidth-1:0] ModBit7Mask = 8'h7F;
  localparam logic [WordWidth-1:0] CtrlMask    = 8'hEF;
  localparam logic [WordWidth-1:0] AltMask     = 8'hF7;

  localparam int FlagShift = 0;
  localparam int FlagCtrl  = 1;
  localparam int FlagAlt   = 2;
  localparam int FlagExt   = 3;

  localparam logic REG_HOLD_TICKS = 1'b0;

  typedef enum logic [ActionWidth-1:0] {
    ACT_KEY   = 2'd0,
    ACT_BREAK = 2'd1,
    ACT_CAPS  = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  typedef struct packed {
    logic                 hit;
    logic [WordWidth-1:0] hi;
    logic [WordWidth-1:0] lo;
    logic [WordWidth-1:0] ch;
  } key_entry_t;

  function automatic key_entry_t mk(input logic [7:0] hi, input logic [7:0] lo,
                                    input logic [7:0] ch);
    key_entry_t e;
    e.hit = 1'b1;
    e.hi  = hi;
    e.lo  = lo;
    e.ch  = ch;
    return e;
  endfunction

  function automatic key_entry_t ext_lookup(input logic [CodeWidth-1:0] code);
    key_entry_t e;
    e = '0;
    case (code)
      8'h11: e = mk(8'hF7, 8'h7F, 8'h11);
      8'h14: e = mk(8'hEF, 8'h7F, 8'h14);
      8'h4A: e = mk(8'h7F, 8'hBF, 8'h4A);
      8'h6B: e = mk(8'hDF, 8'hEF, 8'h6B);
      8'h72: e = mk(8'hEF, 8'hEF, 8'h72);
      8'h74: e = mk(8'hBF, 8'hEF, 8'h74);
      8'h75: e = mk(8'hF7, 8'hEF, 8'h75);
      default: e = '0;
    endcase
    return e;
  endfunction

  function automatic key_entry_t shift_lookup(input logic [CodeWidth-1:0] code);
    key_entry_t e;
    e = '0;
    case (code)
      8'h16: e = mk(8'h7D, 8'h5F, "!");
      8'h25: e = mk(8'h6F, 8'h5F, "$");
      8'h26: e = mk(8'h77, 8'h5F, "#");
      8'h41: e = mk(8'hEF, 8'hBF, "<");
      8'h45: e = mk(8'hFD, 8'hBF, ")");
      8'h46: e = mk(8'hFE, 8'hBF, "(");
      8'h49: e = mk(8'hBF, 8'hBF, ">");
      8'h52: e = mk(8'h7B, 8'h5F, 8'h22);
      8'h55: e = mk(8'hF7, 8'hBF, "+");
      8'h1E: e = mk(8'hFE, 8'hFE, "@");
      8'h2E: e = mk(8'h5F, 8'h5F, "%");
      8'h3D: e = mk(8'h3F, 8'h5F, "&");
      8'h3E: e = mk(8'h7B, 8'h3F, "*");
      8'h4A: e = mk(8'h7F, 8'hBF, 8'h3F);
      8'h4C: e = mk(8'hFB, 8'hBF, ":");
      default: e = '0;
    endcase
    return e;
  endfunction

  function automatic key_entry_t base_lookup(input logic [CodeWidth-1:0] code);
    key_entry_t e;
    e = '0;
    case (code)
      8'h11: e = mk(8'hF7, 8'h7F, "0");
      8'h12: e = mk(8'h7F, 8'h7F, "0");
      8'h14: e = mk(8'hEF, 8'h7F, "0");
      8'h15: e = mk(8'hFD, 8'hF7, "Q");
      8'h16: e = mk(8'hFD, 8'hDF, "1");
      8'h21: e = mk(8'hF7, 8'hFE, "C");
      8'h22: e = mk(8'hFE, 8'hEF, "X");
      8'h23: e = mk(8'hEF, 8'hFE, "D");
      8'h24: e = mk(8'hDF, 8'hFE, "E");
      8'h25: e = mk(8'hEF, 8'hDF, "4");
      8'h26: e = mk(8'hF7, 8'hDF, "3");
      8'h29: e = mk(8'h7F, 8'hEF, " ");
      8'h31: e = mk(8'hBF, 8'hFD, "N");
      8'h33: e = mk(8'hFE, 8'hFD, "H");
      8'h34: e = mk(8'h7F, 8'hFE, "G");
      8'h35: e = mk(8'hFD, 8'hEF, "Y");
      8'h36: e = mk(8'hBF, 8'hDF, "6");
      8'h41: e = mk(8'hEF, 8'hBF, ",");
      8'h42: e = mk(8'hF7, 8'hFD, "K");
      8'h43: e = mk(8'hFD, 8'hFD, "I");
      8'h44: e = mk(8'h7F, 8'hFD, "O");
      8'h45: e = mk(8'hFE, 8'hDF, "0");
      8'h46: e = mk(8'hFD, 8'hBF, "9");
      8'h49: e = mk(8'hBF, 8'hBF, ".");
      8'h52: e = mk(8'h7F, 8'h5F, 8'h27);
      8'h55: e = mk(8'hDF, 8'hBF, "=");
      8'h58: e = mk(8'h7E, 8'h7E, "0");
      8'h59: e = mk(8'h7F, 8'h7F, "0");
      8'h69: e = mk(8'hFD, 8'hDF, "1");
      8'h70: e = mk(8'hFE, 8'hDF, "0");
      8'h71: e = mk(8'hBF, 8'hBF, ".");
      8'h72: e = mk(8'hFB, 8'hDF, "2");
      8'h73: e = mk(8'hDF, 8'hDF, "5");
      8'h74: e = mk(8'hBF, 8'hDF, "6");
      8'h75: e = mk(8'hFE, 8'hBF, "8");
      8'h76: e = mk(8'hFD, 8'h7F, "0");
      8'h79: e = mk(8'hF7, 8'hBF, "+");
      8'h05: e = mk(8'hDF, 8'h7F, "0");
      8'h06: e = mk(8'hBF, 8'h7F, "0");
      8'h1A: e = mk(8'hFB, 8'hEF, "Z");
      8'h1B: e = mk(8'hF7, 8'hF7, "S");
      8'h1C: e = mk(8'hFD, 8'hFE, "A");
      8'h1D: e = mk(8'h7F, 8'hF7, "W");
      8'h1E: e = mk(8'hFB, 8'hDF, "2");
      8'h2A: e = mk(8'hBF, 8'hF7, "V");
      8'h2B: e = mk(8'hBF, 8'hFE, "F");
      8'h2C: e = mk(8'hEF, 8'hF7, "T");
      8'h2D: e = mk(8'hFB, 8'hF7, "R");
      8'h2E: e = mk(8'hDF, 8'hDF, "5");
      8'h32: e = mk(8'hFB, 8'hFE, "B");
      8'h3A: e = mk(8'hDF, 8'hFD, "M");
      8'h3B: e = mk(8'hFB, 8'hFD, "J");
      8'h3C: e = mk(8'hDF, 8'hF7, "U");
      8'h3D: e = mk(8'h7F, 8'hDF, "7");
      8'h3E: e = mk(8'hFE, 8'hBF, "8");
      8'h4A: e = mk(8'h7F, 8'hBF, "/");
      8'h4B: e = mk(8'hEF, 8'hFD, "L");
      8'h4C: e = mk(8'hF7, 8'hBF, ";");
      8'h4D: e = mk(8'hFE, 8'hF7, "P");
      8'h4E: e = mk(8'hDF, 8'hBF, "-");
      8'h5A: e = mk(8'hFE, 8'h7F, 8'h0A);
      8'h6B: e = mk(8'hEF, 8'hDF, "4");
      8'h6C: e = mk(8'h7F, 8'hDF, "7");
      8'h7A: e = mk(8'hF7, 8'hDF, "3");
      8'h7B: e = mk(8'hDF, 8'hBF, "-");
      8'h7C: e = mk(8'h7B, 8'h3F, "*");
      8'h7D: e = mk(8'hFD, 8'hBF, "9");
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

[hdl/scancode_to_key_matrix_driver.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scancode_to_key_matrix_driver
// Turns keyboard events into active-low matrix latch words and times how
// long they stay driven onto the matrix.
// ---------------------------------------------------------------------------
// the result of each input transaction is registered in the output register
// throughput: one item per cycle; a new item enters whenever the output
//   register is empty or being emptied in the same cycle
// reset: latch words go to 0xFF, drive off, hold count 0, hold_ticks 5,
//   no result pending
module scancode_to_key_matrix_driver (
  input  logic                                  clk,
  input  logic                                  rst,
  // input stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [sckm_pkg::InDataWidth-1:0]      s_tdata,  // scan_code, modifier_flags
  input  logic [sckm_pkg::ActionWidth-1:0]      s_tuser,  // action
  // result stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // latch_high, latch_low, matrix_on, key_char, key_found
  output logic [sckm_pkg::OutDataWidth-1:0]     m_tdata,
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sckm_pkg::ApbAddrWidth-1:0]     paddr,
  input  logic [sckm_pkg::ApbDataWidth-1:0]     pwdata,
  output logic [sckm_pkg::ApbDataWidth-1:0]     prdata,
  output logic                                  pready
);
  import sckm_pkg::*;

  logic [WordWidth-1:0] hold_ticks;
  logic [WordWidth-1:0] high_word, high_word_next;
  logic [WordWidth-1:0] low_word, low_word_next;
  logic                 drive_active, drive_active_next;
  logic [WordWidth-1:0] hold_count, hold_count_next;
  logic [WordWidth-1:0] key_char_next;
  logic                 key_found_next;

  logic [OutDataWidth-1:0] result;

  action_t              action;
  logic [CodeWidth-1:0] scan_code;
  logic [FlagWidth-1:0] modifier_flags;
  key_entry_t           ext_e, shift_e, base_e, sel_e;
  logic [WordWidth-1:0] key_hi, key_lo;
  logic                 in_xfer;

  assign action         = action_t'(s_tuser);
  assign scan_code      = s_tdata[CodeWidth-1:0];
  assign modifier_flags = s_tdata[CodeWidth +: FlagWidth];

  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  // configuration port
  assign pready = 1'b1;
  assign prdata = {{(ApbDataWidth-WordWidth){1'b0}}, hold_ticks};

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= HoldTicksReset;
    end else if (psel && penable && pwrite && pready
                 && paddr[ApbAddrWidth-1] == REG_HOLD_TICKS) begin
      hold_ticks <= pwdata[WordWidth-1:0];
    end
  end

  // three-level lookup
  always_comb begin
    ext_e   = ext_lookup(scan_code);
    shift_e = shift_lookup(scan_code);
    base_e  = base_lookup(scan_code);
    if (modifier_flags[FlagExt] && ext_e.hit) begin
      sel_e = ext_e;
    end else if (!modifier_flags[FlagExt] && modifier_flags[FlagShift] && shift_e.hit) begin
      sel_e = shift_e;
    end else begin
      sel_e = base_e;
    end
    key_hi = sel_e.hi;
    key_lo = sel_e.lo;
    if (modifier_flags[FlagShift]) begin
      key_hi = key_hi & ModBit7Mask;
      key_lo = key_lo & ModBit7Mask;
    end
    if (modifier_flags[FlagCtrl]) begin
      key_hi = key_hi & CtrlMask;
      key_lo = key_lo & ModBit7Mask;
    end
    if (modifier_flags[FlagAlt]) begin
      key_hi = key_hi & AltMask;
      key_lo = key_lo & ModBit7Mask;
    end
  end

  always_comb begin
    high_word_next    = high_word;
    low_word_next     = low_word;
    drive_active_next = drive_active;
    hold_count_next   = hold_count;
    key_char_next     = NoChar;
    key_found_next    = 1'b0;
    unique case (action)
      ACT_KEY: begin
        if (sel_e.hit) begin
          high_word_next    = key_hi;
          low_word_next     = key_lo;
          drive_active_next = 1'b1;
          hold_count_next   = hold_ticks;
          key_char_next     = sel_e.ch;
          key_found_next    = 1'b1;
        end
      end
      ACT_BREAK: begin
        high_word_next    = BreakHigh;
        low_word_next     = BreakLow;
        drive_active_next = 1'b1;
        hold_count_next   = hold_ticks;
        key_char_next     = BreakChar;
        key_found_next    = 1'b1;
      end
      ACT_CAPS: begin
        high_word_next    = CapsHigh;
        low_word_next     = CapsLow;
        drive_active_next = 1'b1;
        hold_count_next   = hold_ticks;
        key_char_next     = CapsChar;
        key_found_next    = 1'b1;
      end
      ACT_TICK: begin
        if (drive_active) begin
          // a count of zero or one ends the hold
          if (hold_count <= WordWidth'(1)) begin
            hold_count_next   = '0;
            drive_active_next = 1'b0;
          end else begin
            hold_count_next = hold_count - WordWidth'(1);
          end
        end
      end
      default: begin
        high_word_next = high_word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_word    <= WordIdle;
      low_word     <= WordIdle;
      drive_active <= 1'b0;
      hold_count   <= '0;
    end else if (in_xfer) begin
      high_word    <= high_word_next;
      low_word     <= low_word_next;
      drive_active <= drive_active_next;
      hold_count   <= hold_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      result <= {6'b0, key_found_next, key_char_next, drive_active_next,
                 low_word_next, high_word_next};
    end
  end

  assign m_tdata = result;

  // a released drive always has an empty hold count
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !drive_active |-> hold_count == '0)
    else $error("hold count nonzero while drive is off");

  // a latching item always leaves the matrix driven
  a_found_drives: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[25] |-> m_tdata[16])
    else $error("key found but matrix not driven");

  // items that latch nothing report no character
  a_no_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[25] |-> m_tdata[24:17] == NoChar)
    else $error("character reported without a latch");

  // the latch state changes only on an input transaction
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !in_xfer |=> $stable(high_word) && $stable(low_word) && $stable(hold_count))
    else $error("state changed without an input transaction");

endmodule
